FILE: rtl/dpp_pkg.sv
// ----------------------------------------------------------------------------
// dpp_pkg: shared types and constants of the depth pixel to point converter
// Item structs, configuration register indexes, reset values and image limits.
// ----------------------------------------------------------------------------
package dpp_pkg;

    // image limits; a pixel at or beyond them gives no point
    localparam int unsigned MAX_COLUMNS = 4096;
    localparam int unsigned MAX_ROWS    = 4096;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_UNIT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_Y = 3'd4;

    // register reset values
    localparam logic [23:0] RST_DEPTH_UNIT  = 24'd16777;
    localparam logic [15:0] RST_CENTER_X    = 16'd5208;
    localparam logic [15:0] RST_CENTER_Y    = 16'd4056;
    localparam logic [23:0] RST_INV_FOCAL_X = 24'd32388;
    localparam logic [23:0] RST_INV_FOCAL_Y = 24'd32326;

    // one depth pixel with its colour
    typedef struct packed {
        logic [15:0] depth_raw;
        logic [7:0]  blue_in;
        logic [7:0]  green_in;
        logic [7:0]  red_in;
        logic [11:0] pixel_column;
        logic [11:0] pixel_row;
    } t_pixel;

    // one coloured 3-D point
    typedef struct packed {
        logic signed [31:0] x_pos;
        logic signed [31:0] y_pos;
        logic [30:0]        z_pos;
        logic [7:0]         blue_out;
        logic [7:0]         green_out;
        logic [7:0]         red_out;
    } t_point;

endpackage

FILE: rtl/depth_pixel_to_point.sv
// ----------------------------------------------------------------------------
// depth_pixel_to_point: pinhole back-projection of depth pixels
// Turns a stream of depth pixels into coloured points in Q16.16 metres.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock. The rate is one item per cycle
// whenever the output side does not stall. The pipeline has five register
// stages: the depth product, two multiplier stages per axis, the sum, and the
// rounding/saturation stage that feeds the output register. Pixels with zero
// depth or outside the image make no point and leave a bubble. A stall on the
// output holds the whole pipeline. Configuration registers are written through
// a plain write port and should change only while no item is in flight.
module depth_pixel_to_point (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [dpp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [dpp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // pixel input
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  dpp_pkg::t_pixel               i_in_data,
    // point output
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output dpp_pkg::t_point               o_out_data
);

    // configuration registers
    logic [23:0] r_depth_unit;
    logic [15:0] r_center_x;
    logic [15:0] r_center_y;
    logic [23:0] r_inv_focal_x;
    logic [23:0] r_inv_focal_y;

    // pipeline control
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic w_adv;
    logic w_accept;
    logic n_v1;

    // stage 1: depth product and pixel offsets
    logic [39:0] r1_zp;
    logic        r1_negx, r1_negy;
    logic [15:0] r1_magx, r1_magy;
    logic [23:0] r1_bgr;
    logic signed [16:0] n_dx, n_dy;
    logic [16:0] n_magx, n_magy;

    // stage 2: z and offset times z
    logic [47:0] r2_ax, r2_ay;
    logic [30:0] r2_z;
    logic        r2_negx, r2_negy;
    logic [23:0] r2_bgr;
    logic [31:0] n_zt;

    // stage 3: partial products with the reciprocal focal lengths
    logic [47:0] r3_q1x, r3_q0x, r3_q1y, r3_q0y;
    logic [30:0] r3_z;
    logic        r3_negx, r3_negy;
    logic [23:0] r3_bgr;

    // stage 4: combined product and sticky remainder
    logic [48:0] r4_sx, r4_sy;
    logic        r4_remx, r4_remy;
    logic [30:0] r4_z;
    logic        r4_negx, r4_negy;
    logic [23:0] r4_bgr;
    logic [48:0] n_sx, n_sy;

    // stage 5: output register
    dpp_pkg::t_point r_out;
    dpp_pkg::t_point n_out;

    // floor of the signed quotient, saturated to 32 bits
    function automatic logic [31:0] axis_final(input logic neg, input logic [44:0] quo,
                                               input logic rem);
        logic [45:0] q;
        logic [31:0] res;
        q = {1'b0, quo} + {45'd0, rem};
        if (!neg) begin
            if (quo > 45'h0_7FFF_FFFF) begin
                res = 32'h7FFF_FFFF;
            end else begin
                res = quo[31:0];
            end
        end else begin
            if (q > 46'h0_8000_0000) begin
                res = 32'h8000_0000;
            end else begin
                res = 32'd0 - q[31:0];
            end
        end
        return res;
    endfunction

    // write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_unit  <= dpp_pkg::RST_DEPTH_UNIT;
            r_center_x    <= dpp_pkg::RST_CENTER_X;
            r_center_y    <= dpp_pkg::RST_CENTER_Y;
            r_inv_focal_x <= dpp_pkg::RST_INV_FOCAL_X;
            r_inv_focal_y <= dpp_pkg::RST_INV_FOCAL_Y;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                dpp_pkg::REG_DEPTH_UNIT:  r_depth_unit  <= i_cfg_data;
                dpp_pkg::REG_CENTER_X:    r_center_x    <= i_cfg_data[15:0];
                dpp_pkg::REG_CENTER_Y:    r_center_y    <= i_cfg_data[15:0];
                dpp_pkg::REG_INV_FOCAL_X: r_inv_focal_x <= i_cfg_data;
                dpp_pkg::REG_INV_FOCAL_Y: r_inv_focal_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // hold the whole pipeline while a finished point waits
    assign w_adv      = !(r_v5 && i_out_stall);
    assign o_in_stall = !w_adv;
    assign w_accept   = i_in_valid && w_adv;

    // drop pixels without depth or outside the image
    always_comb begin
        n_v1 = w_accept && (i_in_data.depth_raw != 16'd0)
            && (32'(i_in_data.pixel_column) < dpp_pkg::MAX_COLUMNS)
            && (32'(i_in_data.pixel_row) < dpp_pkg::MAX_ROWS);
    end

    // advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= n_v1;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // stage 1: offsets from the principal point as sign and magnitude
    always_comb begin
        n_dx   = $signed({1'b0, i_in_data.pixel_column, 4'b0000}) - $signed({1'b0, r_center_x});
        n_dy   = $signed({1'b0, i_in_data.pixel_row, 4'b0000}) - $signed({1'b0, r_center_y});
        n_magx = n_dx[16] ? 17'(-n_dx) : 17'(n_dx);
        n_magy = n_dy[16] ? 17'(-n_dy) : 17'(n_dy);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_zp   <= i_in_data.depth_raw * r_depth_unit;
            r1_negx <= n_dx[16];
            r1_negy <= n_dy[16];
            r1_magx <= n_magx[15:0];
            r1_magy <= n_magy[15:0];
            r1_bgr  <= {i_in_data.blue_in, i_in_data.green_in, i_in_data.red_in};
        end
    end

    // stage 2: scale offsets by z, saturate z
    assign n_zt = r1_zp[39:8];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_ax   <= r1_magx * n_zt;
            r2_ay   <= r1_magy * n_zt;
            r2_z    <= n_zt[31] ? 31'h7FFF_FFFF : n_zt[30:0];
            r2_negx <= r1_negx;
            r2_negy <= r1_negy;
            r2_bgr  <= r1_bgr;
        end
    end

    // stage 3: split products by the reciprocal focal lengths
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_q1x  <= r2_ax[47:24] * r_inv_focal_x;
            r3_q0x  <= r2_ax[23:0] * r_inv_focal_x;
            r3_q1y  <= r2_ay[47:24] * r_inv_focal_y;
            r3_q0y  <= r2_ay[23:0] * r_inv_focal_y;
            r3_z    <= r2_z;
            r3_negx <= r2_negx;
            r3_negy <= r2_negy;
            r3_bgr  <= r2_bgr;
        end
    end

    // stage 4: combine partial products, keep a sticky bit of the dropped part
    always_comb begin
        n_sx = {1'b0, r3_q1x} + {25'd0, r3_q0x[47:24]};
        n_sy = {1'b0, r3_q1y} + {25'd0, r3_q0y[47:24]};
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_sx   <= n_sx;
            r4_sy   <= n_sy;
            r4_remx <= (n_sx[3:0] != 4'd0) || (r3_q0x[23:0] != 24'd0);
            r4_remy <= (n_sy[3:0] != 4'd0) || (r3_q0y[23:0] != 24'd0);
            r4_z    <= r3_z;
            r4_negx <= r3_negx;
            r4_negy <= r3_negy;
            r4_bgr  <= r3_bgr;
        end
    end

    // stage 5: floor, saturate and apply sign
    always_comb begin
        n_out.x_pos     = axis_final(r4_negx, r4_sx[48:4], r4_remx);
        n_out.y_pos     = axis_final(r4_negy, r4_sy[48:4], r4_remy);
        n_out.z_pos     = r4_z;
        n_out.blue_out  = r4_bgr[23:16];
        n_out.green_out = r4_bgr[15:8];
        n_out.red_out   = r4_bgr[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_v5;
    assign o_out_data  = r_out;

endmodule

FILE: rtl/dpp_checker.sv
// ----------------------------------------------------------------------------
// dpp_checker: port-level checks of the depth pixel to point converter
// Watches the handshakes and the point fields at the top level's ports.
// ----------------------------------------------------------------------------
module dpp_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           o_in_stall,
    input  logic                           o_out_valid,
    input  logic                           i_out_stall,
    input  dpp_pkg::t_point                o_out_data
);

    // a stalled point stays offered and unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("point dropped or changed while stalled");

    // input stalls only behind a waiting point
    a_in_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled with no point waiting");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("point offered right after reset");

    // a point at zero depth sits on the optical center
    a_zero_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.z_pos == 31'd0)
            |-> (o_out_data.x_pos == 32'sd0) && (o_out_data.y_pos == 32'sd0))
        else $error("nonzero x or y at zero depth");

endmodule

bind depth_pixel_to_point dpp_checker u_dpp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

FILE: sim/tb_depth_pixel_to_point.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_depth_pixel_to_point: self-checking bench of the depth pixel converter
// Streams pixels through the back-projection block under several register
// settings and random idling on both sides. Each accepted pixel is projected
// by a local pinhole model, and every point out of the block is checked field
// by field against the oldest predicted point.
// ----------------------------------------------------------------------------
module tb_depth_pixel_to_point;

    localparam int HOLDOFF_CYCLES  = 80;
    localparam int SETTLE_CYCLES   = 10;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int BATCH_PIXELS    = 50;

    // kinds of register settings used in the random part
    typedef enum int {
        CAMERA_LIKE,
        FULL_RANGE,
        EXTREMES
    } t_setting_kind;

    // ------------------------------------------------------------------------
    // Point scoreboard: projects accepted pixels, compares returned points
    // ------------------------------------------------------------------------
    class point_scoreboard;
        logic [23:0]     depth_unit;
        logic [15:0]     center_x;
        logic [15:0]     center_y;
        logic [23:0]     inv_focal_x;
        logic [23:0]     inv_focal_y;
        dpp_pkg::t_point expected_points[$];
        int              mismatches;
        int              pixels_seen;
        int              empty_pixels;
        int              points_checked;
        int              saturated_coords;

        function new();
            depth_unit  = dpp_pkg::RST_DEPTH_UNIT;
            center_x    = dpp_pkg::RST_CENTER_X;
            center_y    = dpp_pkg::RST_CENTER_Y;
            inv_focal_x = dpp_pkg::RST_INV_FOCAL_X;
            inv_focal_y = dpp_pkg::RST_INV_FOCAL_Y;
        endfunction

        // mirror a register write; unknown indexes are dropped
        function void write_reg(logic [dpp_pkg::CFG_IDX_W-1:0] idx,
                                logic [dpp_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                dpp_pkg::REG_DEPTH_UNIT:  depth_unit  = data;
                dpp_pkg::REG_CENTER_X:    center_x    = data[15:0];
                dpp_pkg::REG_CENTER_Y:    center_y    = data[15:0];
                dpp_pkg::REG_INV_FOCAL_X: inv_focal_x = data;
                dpp_pkg::REG_INV_FOCAL_Y: inv_focal_y = data;
                default: ;
            endcase
        endfunction

        // floor(d * z * k / 2^28), clamped to the signed 32-bit range
        function logic signed [31:0] backproject_axis(logic signed [17:0] d,
                                                      logic [31:0] z, logic [23:0] k);
            logic signed [79:0] d_w;
            logic signed [79:0] z_w;
            logic signed [79:0] k_w;
            logic signed [79:0] scaled;
            d_w = d;
            z_w = {48'd0, z};
            k_w = {56'd0, k};
            scaled = (d_w * z_w * k_w) >>> 28;
            if (scaled > 80'sh7FFF_FFFF) begin
                saturated_coords++;
                return 32'sh7FFF_FFFF;
            end
            if (scaled < -80'sh8000_0000) begin
                saturated_coords++;
                return 32'sh8000_0000;
            end
            return scaled[31:0];
        endfunction

        function int pending();
            return expected_points.size();
        endfunction

        // predict the point of an accepted pixel, if it makes one
        function void note_pixel(dpp_pkg::t_pixel p);
            logic [39:0]        depth_scaled;
            logic [31:0]        z_raw;
            logic signed [17:0] dx;
            logic signed [17:0] dy;
            dpp_pkg::t_point    pt;
            pixels_seen++;
            if (p.depth_raw == 0 || p.pixel_column >= dpp_pkg::MAX_COLUMNS
                    || p.pixel_row >= dpp_pkg::MAX_ROWS) begin
                empty_pixels++;
                return;
            end
            depth_scaled = p.depth_raw * depth_unit;
            z_raw = depth_scaled[39:8];
            dx = $signed({2'b00, p.pixel_column, 4'b0000}) - $signed({2'b00, center_x});
            dy = $signed({2'b00, p.pixel_row, 4'b0000}) - $signed({2'b00, center_y});
            pt.x_pos = backproject_axis(dx, z_raw, inv_focal_x);
            pt.y_pos = backproject_axis(dy, z_raw, inv_focal_y);
            if (z_raw > 32'h7FFF_FFFF) begin
                pt.z_pos = 31'h7FFF_FFFF;
                saturated_coords++;
            end else begin
                pt.z_pos = z_raw[30:0];
            end
            pt.blue_out  = p.blue_in;
            pt.green_out = p.green_in;
            pt.red_out   = p.red_in;
            expected_points = {expected_points, pt};
        endfunction

        task report(string msg);
            mismatches++;
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        endtask

        // compare one returned point with the oldest prediction
        task check_point(dpp_pkg::t_point got);
            dpp_pkg::t_point want;
            if (expected_points.size() == 0) begin
                report($sformatf("point with no pixel pending: x=%0d y=%0d z=%0d",
                                 got.x_pos, got.y_pos, got.z_pos));
                return;
            end
            want = expected_points.pop_front();
            points_checked++;
            if (got.x_pos !== want.x_pos)
                report($sformatf("point %0d x_pos got %0d want %0d",
                                 points_checked, got.x_pos, want.x_pos));
            if (got.y_pos !== want.y_pos)
                report($sformatf("point %0d y_pos got %0d want %0d",
                                 points_checked, got.y_pos, want.y_pos));
            if (got.z_pos !== want.z_pos)
                report($sformatf("point %0d z_pos got %0d want %0d",
                                 points_checked, got.z_pos, want.z_pos));
            if (got.blue_out !== want.blue_out)
                report($sformatf("point %0d blue got %0d want %0d",
                                 points_checked, got.blue_out, want.blue_out));
            if (got.green_out !== want.green_out)
                report($sformatf("point %0d green got %0d want %0d",
                                 points_checked, got.green_out, want.green_out));
            if (got.red_out !== want.red_out)
                report($sformatf("point %0d red got %0d want %0d",
                                 points_checked, got.red_out, want.red_out));
        endtask

        // flag predictions that never came out
        task flush_leftovers();
            while (expected_points.size() != 0) begin
                void'(expected_points.pop_front());
                report("predicted point never returned");
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Signals and instance
    // ------------------------------------------------------------------------
    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [dpp_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [dpp_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                           i_in_valid;
    logic                           o_in_stall;
    dpp_pkg::t_pixel                i_in_data;
    logic                           o_out_valid;
    logic                           i_out_stall;
    dpp_pkg::t_point                o_out_data;

    point_scoreboard board;
    int  send_idle_pct;
    int  stall_pct;
    bit  hold_request;
    int  holdoffs_done;
    int  settings_loaded;
    int  idle_cycles;

    // corner pixels: no depth, extreme depth, image corners, center, colours
    dpp_pkg::t_pixel corner_pixels [6] = '{
        '{16'd0,     8'hFF, 8'hFF, 8'hFF, 12'd4095, 12'd4095},
        '{16'd1,     8'h00, 8'h00, 8'h00, 12'd0,    12'd0},
        '{16'd65535, 8'hFF, 8'h00, 8'hAA, 12'd4095, 12'd4095},
        '{16'd65535, 8'h00, 8'hFF, 8'h55, 12'd0,    12'd0},
        '{16'd1000,  8'hAA, 8'h55, 8'hFF, 12'd325,  12'd253},
        '{16'd65535, 8'h55, 8'hAA, 8'h00, 12'd4095, 12'd0}
    };

    depth_pixel_to_point dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // 4 ns clock
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Monitors: record accepted pixels, check accepted points
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            board.note_pixel(i_in_data);
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_point(o_out_data);
    end

    // Watchdog: end the run when no item moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no item moved for %0d cycles", $realtime,
                     WATCHDOG_LIMIT);
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Point receiver: random stalls, plus a long hold-off on request
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                holdoffs_done++;
                i_out_stall <= 1'b1;
                repeat (HOLDOFF_CYCLES) @(posedge i_clk);
            end
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------
    // offer one pixel and hold it until the block takes it
    task send_pixel(input dpp_pkg::t_pixel p);
        i_in_valid <= 1'b1;
        i_in_data  <= p;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // drop valid for a random number of cycles
    task idle_sender();
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // stop sending until every predicted point is back, then settle
    task drain_points(input int settle);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // write one register; the caller lowers the write enable
    task write_reg(input logic [dpp_pkg::CFG_IDX_W-1:0] idx,
                   input logic [dpp_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        board.write_reg(idx, data);
    endtask

    // write all registers, then a stray write to an unused index
    task load_settings(input logic [23:0] du, input logic [23:0] cx, input logic [23:0] cy,
                       input logic [23:0] fx, input logic [23:0] fy);
        int          spare_pick;
        logic [31:0] junk;
        spare_pick = $urandom_range(dpp_pkg::REG_INV_FOCAL_Y + 1,
                                    (1 << dpp_pkg::CFG_IDX_W) - 1);
        junk = $urandom();
        write_reg(dpp_pkg::REG_DEPTH_UNIT, du);
        write_reg(dpp_pkg::REG_CENTER_X, cx);
        write_reg(dpp_pkg::REG_CENTER_Y, cy);
        write_reg(dpp_pkg::REG_INV_FOCAL_X, fx);
        write_reg(dpp_pkg::REG_INV_FOCAL_Y, fy);
        write_reg(spare_pick[dpp_pkg::CFG_IDX_W-1:0], junk[dpp_pkg::CFG_DATA_W-1:0]);
        i_cfg_we <= 1'b0;
        settings_loaded++;
    endtask

    task load_random_settings(input t_setting_kind kind);
        logic [23:0] v [5];
        foreach (v[i]) begin
            case (kind)
                CAMERA_LIKE: v[i] = (i == 1 || i == 2) ? 24'($urandom_range(0, 65535))
                                                       : 24'($urandom_range(1000, 200000));
                FULL_RANGE:  v[i] = 24'($urandom());
                default:     v[i] = $urandom_range(1) ? 24'hFF_FFFF : 24'h00_0000;
            endcase
        end
        load_settings(v[0], v[1], v[2], v[3], v[4]);
    endtask

    // random pixel weighted toward no depth, full depth and image edges
    function dpp_pkg::t_pixel random_pixel();
        dpp_pkg::t_pixel p;
        int              r;
        p = {$urandom(), $urandom()};
        r = $urandom_range(99);
        if (r < 10)
            p.depth_raw = 16'd0;
        else if (r < 20)
            p.depth_raw = 16'hFFFF;
        else if (r < 40)
            p.depth_raw = 16'($urandom_range(1, 4000));
        else
            p.depth_raw = 16'($urandom());
        p.blue_in  = 8'($urandom());
        p.green_in = 8'($urandom());
        r = $urandom_range(99);
        p.pixel_column = (r < 10) ? 12'd0 : (r < 20) ? 12'd4095 : 12'($urandom());
        r = $urandom_range(99);
        p.pixel_row    = (r < 10) ? 12'd0 : (r < 20) ? 12'd4095 : 12'($urandom());
        return p;
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        board           = new();
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        i_in_valid      = 1'b0;
        i_in_data       = '0;
        send_idle_pct   = 9;
        stall_pct       = 71;
        hold_request    = 1'b0;
        holdoffs_done   = 0;
        settings_loaded = 0;
        idle_cycles     = 0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corner pixels under reset values, full scale, centers high, all zero
        for (int s = 0; s < 4; s++) begin
            case (s)
                1: load_settings(24'hFF_FFFF, 24'h00_0000, 24'h00_0000,
                                 24'hFF_FFFF, 24'hFF_FFFF);
                2: load_settings(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF,
                                 24'hFF_FFFF, 24'hFF_FFFF);
                3: load_settings(24'h00_0000, 24'h00_0000, 24'h00_0000,
                                 24'h00_0000, 24'h00_0000);
                default: ;
            endcase
            foreach (corner_pixels[i]) begin
                send_pixel(corner_pixels[i]);
                idle_sender();
            end
            drain_points(SETTLE_CYCLES);
        end

        // random pixels: sender idles lightly, then receiver, then neither
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 9;  stall_pct = 71; end
                1: begin send_idle_pct = 71; stall_pct = 9;  end
                default: begin send_idle_pct = 0; stall_pct = 0; end
            endcase
            for (int batch = 0; batch < 3; batch++) begin
                drain_points(SETTLE_CYCLES);
                load_random_settings(t_setting_kind'(batch));
                for (int n = 0; n < BATCH_PIXELS; n++) begin
                    // fill the pipeline against a stalled receiver
                    if (phase == 2 && n == 10 && batch != 1)
                        hold_request = 1'b1;
                    // pause the sender until every point is back
                    if (phase == 0 && batch == 1 && n == 25)
                        drain_points(0);
                    send_pixel(random_pixel());
                    idle_sender();
                end
            end
        end

        drain_points(SETTLE_CYCLES);
        board.flush_leftovers();

        $display("Run covered %0d pixels (%0d with no point) under %0d register settings",
                 board.pixels_seen, board.empty_pixels, settings_loaded + 1);
        $display("Checked %0d points, %0d saturated coordinates, %0d receiver hold-offs",
                 board.points_checked, board.saturated_coords, holdoffs_done);
        if (board.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: depth_pixel_to_point.f
rtl/dpp_pkg.sv
rtl/depth_pixel_to_point.sv
rtl/dpp_checker.sv
sim/tb_depth_pixel_to_point.sv
